FILE: rtl/hafp_pkg.sv
// shared constants, types and codes for the hole allocator
`timescale 1ns / 1ps

package hafp_pkg;

    // table geometry
    localparam int NUM_HOLES = 8;
    localparam int ADDR_BITS = 16;
    localparam int IDX_BITS  = $clog2(NUM_HOLES);
    localparam int CNT_BITS  = $clog2(NUM_HOLES + 1);

    // fixed field widths of the beats
    localparam int KIND_W  = 1;
    localparam int HIDX_W  = 3;
    localparam int DATA_W  = 16;
    localparam int TAG_W   = 8;
    localparam int POL_W   = 2;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_LOAD = 1'b0;
    localparam logic [KIND_W-1:0] KIND_REQ  = 1'b1;

    // fit policies, the unused code behaves as first fit
    localparam logic [POL_W-1:0] POL_FIRST = 2'd0;
    localparam logic [POL_W-1:0] POL_NEXT  = 2'd1;
    localparam logic [POL_W-1:0] POL_BEST  = 2'd2;

    typedef logic [ADDR_BITS-1:0] t_addr;
    typedef logic [IDX_BITS-1:0]  t_idx;
    typedef logic [CNT_BITS-1:0]  t_cnt;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    // candidate handed from cell to cell
    typedef struct packed {
        logic  found;
        t_idx  idx;
        t_addr size;
        t_addr start;
    } t_link;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic             load;
        t_idx             load_idx;
        t_addr            load_start;
        t_addr            load_size;
        logic             commit;
        t_idx             commit_idx;
        t_addr            need;
        logic [POL_W-1:0] policy;
        t_idx             rover;
    } t_cmd;

endpackage

FILE: rtl/hafp_req_if.sv
// request channel: load and allocation beats
`timescale 1ns / 1ps

interface hafp_req_if;
    import hafp_pkg::*;

    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [HIDX_W-1:0]   hole_index;
    logic [DATA_W-1:0]   hole_start;
    logic [DATA_W-1:0]   hole_size;
    logic [DATA_W-1:0]   request_size;
    logic [TAG_W-1:0]    request_tag;

    modport source (
        output valid, kind, hole_index, hole_start, hole_size, request_size, request_tag,
        input  ready
    );

    modport sink (
        input  valid, kind, hole_index, hole_start, hole_size, request_size, request_tag,
        output ready
    );

endinterface

FILE: rtl/hafp_res_if.sv
// result channel: grant or refusal beats
`timescale 1ns / 1ps

interface hafp_res_if;
    import hafp_pkg::*;

    logic                valid;
    logic                ready;
    logic                granted;
    logic [DATA_W-1:0]   grant_address;
    logic [HIDX_W-1:0]   chosen_hole;
    logic [TAG_W-1:0]    result_tag;

    modport source (
        output valid, granted, grant_address, chosen_hole, result_tag,
        input  ready
    );

    modport sink (
        input  valid, granted, grant_address, chosen_hole, result_tag,
        output ready
    );

endinterface

FILE: rtl/hole_allocator_fit_policies_core.sv
// hole allocator top level: controller, cell chain and result register
//
//  channel   dir  beat contents
//  i_req     in   kind, hole_index, hole_start, hole_size, request_size, request_tag
//  o_res     out  granted, grant_address, chosen_hole, result_tag
//  i_cfg_*   in   fit_policy write, no read-back
//
// a load beat is taken while idle and ready stays high.
// a request walks the candidate through the chain of NUM_HOLES cells, one cell a
// cycle; the result is then captured in the output register, and no next beat
// is taken until the scan has ended and the result register is free.
// the result sits in an output register; if it is still held the commit waits.
// synchronous active-low reset empties every hole, clears the rover and the policy.
`timescale 1ns / 1ps

module hole_allocator_fit_policies_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    hafp_req_if.sink                   i_req,
    hafp_res_if.source                 o_res,
    input  logic                       i_cfg_we,
    input  logic [hafp_pkg::POL_W-1:0] i_cfg_wdata
);
    import hafp_pkg::*;

    t_state             r_state;
    t_state             n_state;
    t_cnt               r_cnt;
    t_cnt               n_cnt;
    t_idx               r_rover;
    logic [POL_W-1:0]   r_policy;
    t_addr              r_need;
    logic [TAG_W-1:0]   r_tag;
    logic               r_out_valid;
    logic               r_granted;
    logic [DATA_W-1:0]  r_grant_address;
    logic [HIDX_W-1:0]  r_chosen_hole;
    logic [TAG_W-1:0]   r_result_tag;

    logic               w_acc_in;
    logic               w_load_ok;
    logic               w_out_free;
    logic               w_done;
    t_link              w_last;
    t_cmd               w_cmd;
    t_link              w_link [NUM_HOLES+1];

    // handshake and command broadcast
    assign i_req.ready = (r_state == ST_IDLE);
    assign w_acc_in    = i_req.valid && i_req.ready;
    assign w_load_ok   = (32'(i_req.hole_index) < NUM_HOLES);
    assign w_out_free  = !r_out_valid || o_res.ready;
    assign w_last      = w_link[NUM_HOLES];
    assign w_done      = (r_state == ST_SCAN) && (r_cnt == CNT_BITS'(NUM_HOLES)) && w_out_free;

    always_comb begin
        w_cmd.load       = w_acc_in && (i_req.kind == KIND_LOAD) && w_load_ok;
        w_cmd.load_idx   = IDX_BITS'(i_req.hole_index);
        w_cmd.load_start = ADDR_BITS'(i_req.hole_start);
        w_cmd.load_size  = ADDR_BITS'(i_req.hole_size);
        w_cmd.commit     = w_done && w_last.found;
        w_cmd.commit_idx = w_last.idx;
        w_cmd.need       = r_need;
        w_cmd.policy     = r_policy;
        w_cmd.rover      = r_rover;
    end

    // chain of cells, fed with an empty candidate
    assign w_link[0] = '0;

    for (genvar g = 0; g < NUM_HOLES; g++) begin : g_cell
        hafp_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cell_idx (IDX_BITS'(g)),
            .i_cmd      (w_cmd),
            .i_link     (w_link[g]),
            .o_link     (w_link[g+1])
        );
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            ST_IDLE: begin
                if (w_acc_in && (i_req.kind == KIND_REQ)) begin
                    n_state = ST_SCAN;
                    n_cnt   = '0;
                end
            end
            ST_SCAN: begin
                if (r_cnt != CNT_BITS'(NUM_HOLES)) begin
                    n_cnt = r_cnt + 1'b1;
                end else if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // policy register and rover
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= POL_FIRST;
            r_rover  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_policy <= i_cfg_wdata;
            end
            if (w_cmd.load) begin
                r_rover <= '0;
            end else if (w_cmd.commit && (r_policy == POL_NEXT)) begin
                r_rover <= w_last.idx;
            end
        end
    end

    // request fields held for the scan
    always_ff @(posedge i_clk) begin
        if (w_acc_in && (i_req.kind == KIND_REQ)) begin
            r_need <= ADDR_BITS'(i_req.request_size);
            r_tag  <= i_req.request_tag;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_granted       <= w_last.found;
            r_grant_address <= w_last.found ? DATA_W'(w_last.start) : '0;
            r_chosen_hole   <= w_last.found ? HIDX_W'(w_last.idx) : '0;
            r_result_tag    <= r_tag;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.granted       = r_granted;
    assign o_res.grant_address = r_grant_address;
    assign o_res.chosen_hole   = r_chosen_hole;
    assign o_res.result_tag    = r_result_tag;

endmodule

FILE: rtl/hafp_cell.sv
// one hole of the table with its stage of the search chain
`timescale 1ns / 1ps

module hafp_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  hafp_pkg::t_idx  i_cell_idx,
    input  hafp_pkg::t_cmd  i_cmd,
    input  hafp_pkg::t_link i_link,
    output hafp_pkg::t_link o_link
);
    import hafp_pkg::*;

    t_addr r_start;
    t_addr r_size;
    t_link r_link;
    t_link n_link;
    logic  w_fits;
    logic  w_take;

    // decide whether this hole beats the candidate from upstream
    always_comb begin
        w_fits = (r_size >= i_cmd.need);
        w_take = 1'b0;
        if (w_fits) begin
            if (!i_link.found) begin
                w_take = 1'b1;
            end else if (i_cmd.policy == POL_BEST) begin
                w_take = (r_size < i_link.size);
            end else if (i_cmd.policy == POL_NEXT) begin
                w_take = (i_link.idx < i_cmd.rover) && (i_cell_idx >= i_cmd.rover);
            end
        end
        if (w_take) begin
            n_link.found = 1'b1;
            n_link.idx   = i_cell_idx;
            n_link.size  = r_size;
            n_link.start = r_start;
        end else begin
            n_link = i_link;
        end
    end

    // hole contents: load writes, a grant cuts from the front
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
            r_size  <= '0;
        end else if (i_cmd.load && (i_cmd.load_idx == i_cell_idx)) begin
            r_start <= i_cmd.load_start;
            r_size  <= i_cmd.load_size;
        end else if (i_cmd.commit && (i_cmd.commit_idx == i_cell_idx)) begin
            r_start <= r_start + i_cmd.need;
            r_size  <= r_size - i_cmd.need;
        end
    end

    // hand the candidate on to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link <= '0;
        end else begin
            r_link <= n_link;
        end
    end

    assign o_link = r_link;

endmodule

FILE: rtl/hafp_chk.sv
// port-level checks of the hole allocator and their bind
`timescale 1ns / 1ps

module hafp_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_req_valid,
    input logic                        i_req_ready,
    input logic [hafp_pkg::KIND_W-1:0] i_req_kind,
    input logic                        i_res_valid,
    input logic                        i_res_ready,
    input logic                        i_res_granted,
    input logic [hafp_pkg::DATA_W-1:0] i_res_grant_address,
    input logic [hafp_pkg::HIDX_W-1:0] i_res_chosen_hole,
    input logic [hafp_pkg::TAG_W-1:0]  i_res_result_tag
);
    import hafp_pkg::*;

    // no result beat straight after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid after reset");

    // a refusal carries zero address and hole
    a_refusal_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_granted) |-> (i_res_grant_address == '0)
                                            && (i_res_chosen_hole == '0))
        else $error("refusal with non-zero address or hole");

    // a request occupies the block, the next beat waits for the scan
    a_req_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready && (i_req_kind == KIND_REQ)) |=> !i_req_ready)
        else $error("beat taken during a scan");

    // a load gives no result and leaves the block ready
    a_load_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready && (i_req_kind == KIND_LOAD)) |=> i_req_ready)
        else $error("load stalled the request channel");

    // a stalled result beat holds
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=> i_res_valid && $stable(i_res_granted)
            && $stable(i_res_grant_address) && $stable(i_res_chosen_hole)
            && $stable(i_res_result_tag))
        else $error("stalled result beat changed");

endmodule

bind hole_allocator_fit_policies_core hafp_chk u_hafp_chk (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_req_valid         (i_req.valid),
    .i_req_ready         (i_req.ready),
    .i_req_kind          (i_req.kind),
    .i_res_valid         (o_res.valid),
    .i_res_ready         (o_res.ready),
    .i_res_granted       (o_res.granted),
    .i_res_grant_address (o_res.grant_address),
    .i_res_chosen_hole   (o_res.chosen_hole),
    .i_res_result_tag    (o_res.result_tag)
);
